@@ rtl/aip_pkg.sv @@
package aip_pkg;

    localparam int CHAR_W  = 8;
    localparam int MAG_W   = 64;
    localparam int DIGIT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // characters handled inside the prefix window
    localparam int PREFIX_LENGTH = 3;
    localparam logic [1:0] POS_MAX = 2'(PREFIX_LENGTH);

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_O  = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_BAD_SIGN  = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BASE_BIN = 2'd0,
        BASE_OCT = 2'd1,
        BASE_DEC = 2'd2,
        BASE_HEX = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        REG_SIGN_MODE     = 2'd0,
        REG_BASE_MODE     = 2'd1,
        REG_RESULT_SIGNED = 2'd2,
        REG_RESULT_WIDTH  = 2'd3
    } reg_idx_t;

    localparam logic [1:0] SIGN_DETECT = 2'd0;
    localparam logic [1:0] SIGN_POS    = 2'd1;
    localparam logic [1:0] SIGN_NEG    = 2'd2;

    localparam logic [2:0] BASE_MODE_AUTO = 3'd4;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef struct packed {
        logic [1:0]       pos;
        logic [MAG_W-1:0] mag;
        logic             neg;
        base_t            base;
        logic             seen_sign;
        logic             seen_pz;
        logic             pending;
        logic             seen_digit;
        status_t          err;
    } state_t;

    // finished string waiting for the range check
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        status_t          err;
        logic             sgn;
        logic [1:0]       width;
    } fin_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    function automatic digit_t digit_of(logic [CHAR_W-1:0] ch, base_t base);
        digit_t             res;
        logic [CHAR_W-1:0]  diff;
        res.valid = 1'b1;
        diff      = '0;
        if (ch inside {[CH_ZERO:CH_NINE]}) begin
            diff = ch - CH_ZERO;
        end else if (base == BASE_HEX && (ch inside {[CH_LO_A:CH_LO_F]})) begin
            diff = ch - CH_LO_A + 8'd10;
        end else if (base == BASE_HEX && (ch inside {[CH_UP_A:CH_UP_F]})) begin
            diff = ch - CH_UP_A + 8'd10;
        end else begin
            res.valid = 1'b0;
        end
        res.digit = diff[DIGIT_W-1:0];
        if (base == BASE_BIN && diff > 8'd1) res.valid = 1'b0;
        if (base == BASE_OCT && diff > 8'd7) res.valid = 1'b0;
        return res;
    endfunction

    function automatic logic [8:0] radix_sq(base_t base);
        logic [8:0] r;
        case (base)
            BASE_BIN: r = 9'd4;
            BASE_OCT: r = 9'd64;
            BASE_DEC: r = 9'd100;
            BASE_HEX: r = 9'd256;
            default:  r = 9'd100;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/aip_step.sv @@
module aip_step (
    input  logic [aip_pkg::CHAR_W-1:0] ch,
    input  logic [1:0]                 sign_mode,
    input  logic [2:0]                 base_mode,
    input  aip_pkg::state_t            st_cur,
    output aip_pkg::state_t            st_upd
);
    import aip_pkg::*;

    logic            sign_detect;
    logic            base_detect;
    state_t          start;
    state_t          cur;
    state_t          nxt;
    status_t         stat;
    digit_t          dg;
    logic [MAG_W+3:0] shifted;
    logic [MAG_W+3:0] app_sum;
    status_t         app_stat;
    logic [16:0]     dbl_sum;

    assign sign_detect = (sign_mode != SIGN_POS) && (sign_mode != SIGN_NEG);
    assign base_detect = base_mode[2];

    always_comb begin
        start            = '0;
        start.neg        = (sign_mode == SIGN_NEG);
        start.base       = base_detect ? BASE_DEC : base_t'(base_mode[1:0]);
        start.err        = ST_OK;
        cur = (st_cur.pos == 2'd0) ? start : st_cur;
    end

    // one digit appended: mag * radix + digit, overflow shows in the top nibble
    always_comb begin
        dg = digit_of(ch, cur.base);
        case (cur.base)
            BASE_BIN: shifted = {4'd0, cur.mag} << 1;
            BASE_OCT: shifted = {4'd0, cur.mag} << 3;
            BASE_DEC: shifted = ({4'd0, cur.mag} << 3) + ({4'd0, cur.mag} << 1);
            BASE_HEX: shifted = {4'd0, cur.mag} << 4;
            default:  shifted = {4'd0, cur.mag};
        endcase
        app_sum = shifted + (MAG_W+4)'(dg.digit);
        if (!dg.valid) app_stat = ST_BAD_DIGIT;
        else if (|app_sum[MAG_W+3:MAG_W]) app_stat = ST_RANGE;
        else app_stat = ST_OK;
        // held prefix zero plus this digit; magnitude is below 256 here
        dbl_sum = 17'(cur.mag[7:0]) * 17'(radix_sq(cur.base)) + 17'(dg.digit);
    end

    always_comb begin
        nxt  = cur;
        stat = ST_OK;
        if (cur.err == ST_OK) begin
            if (cur.pos != POS_MAX) begin
                case (ch)
                    CH_PLUS, CH_MINUS: begin
                        if (!sign_detect) begin
                            stat = ST_BAD_SIGN;
                        end else if (cur.seen_sign || cur.seen_pz || cur.seen_digit) begin
                            stat = ST_BAD_DIGIT;
                        end else begin
                            nxt.neg       = (ch == CH_MINUS);
                            nxt.seen_sign = 1'b1;
                        end
                    end
                    CH_ZERO: begin
                        if (!base_detect || cur.seen_digit) begin
                            stat = app_stat;
                            if (app_stat == ST_OK) nxt.mag = app_sum[MAG_W-1:0];
                        end else begin
                            nxt.seen_pz = 1'b1;
                            nxt.pending = 1'b1;
                        end
                    end
                    CH_LO_B, CH_LO_O, CH_LO_X: begin
                        if (!base_detect || !cur.pending) begin
                            stat = app_stat;
                            if (app_stat == ST_OK) nxt.mag = app_sum[MAG_W-1:0];
                        end else begin
                            if (ch == CH_LO_B) nxt.base = BASE_BIN;
                            else if (ch == CH_LO_O) nxt.base = BASE_OCT;
                            else nxt.base = BASE_HEX;
                            nxt.pending = 1'b0;
                        end
                    end
                    default: begin
                        nxt.pending    = 1'b0;
                        nxt.seen_digit = 1'b1;
                        if (cur.pending) begin
                            stat = dg.valid ? ST_OK : ST_BAD_DIGIT;
                            if (dg.valid) nxt.mag = MAG_W'(dbl_sum);
                        end else begin
                            stat = app_stat;
                            if (app_stat == ST_OK) nxt.mag = app_sum[MAG_W-1:0];
                        end
                    end
                endcase
            end else begin
                stat = app_stat;
                if (app_stat == ST_OK) nxt.mag = app_sum[MAG_W-1:0];
            end
            if (stat != ST_OK) nxt.err = stat;
        end
        nxt.pos = (cur.pos == POS_MAX) ? POS_MAX : cur.pos + 2'd1;
        st_upd = nxt;
    end

endmodule

@@ rtl/aip_range.sv @@
module aip_range (
    input  aip_pkg::fin_t                fin,
    output logic [aip_pkg::MAG_W-1:0]    value,
    output aip_pkg::status_t             status
);
    import aip_pkg::*;

    logic             u_over;
    logic             s_hi;
    logic             s_exact;
    logic             over;
    status_t          stat;

    always_comb begin
        case (fin.width)
            WIDTH_8: begin
                u_over  = |fin.mag[63:8];
                s_hi    = |fin.mag[63:7];
                s_exact = (fin.mag == 64'h80);
            end
            WIDTH_16: begin
                u_over  = |fin.mag[63:16];
                s_hi    = |fin.mag[63:15];
                s_exact = (fin.mag == 64'h8000);
            end
            WIDTH_32: begin
                u_over  = |fin.mag[63:32];
                s_hi    = |fin.mag[63:31];
                s_exact = (fin.mag == 64'h8000_0000);
            end
            default: begin
                u_over  = 1'b0;
                s_hi    = fin.mag[63];
                s_exact = (fin.mag == 64'h8000_0000_0000_0000);
            end
        endcase

        if (!fin.sgn) over = u_over || fin.neg;
        else if (!fin.neg) over = s_hi;
        else over = s_hi && !s_exact;

        stat = fin.err;
        if (stat == ST_OK && fin.mag != '0 && over) stat = ST_RANGE;

        if (stat != ST_OK) value = '0;
        else if (fin.sgn && fin.neg) value = '0 - fin.mag;
        else value = fin.mag;
        status = stat;
    end

endmodule

@@ rtl/ascii_integer_parser.sv @@
// Channel   | Direction | Ports                              | Handshake
// s_        | in        | s_char_code, s_is_last             | s_valid / s_ready
// m_        | out       | m_value, m_status                  | m_valid / m_ready
// cfg_      | in        | cfg_index, cfg_data                | cfg_valid / cfg_ready
//
// One character item per cycle while s_ready is high. A result's last character
// is taken into the input register, the digit step loads the finish register,
// then the range check loads the result register.
// The magnitude update (shift-add by the radix plus a 68-bit carry check)
// is combinational, so characters of one string follow back to back.
// Synchronous active-low reset clears the valids and the string position and sets the config defaults.
// s_ready drops only when a last item waits, both result stages are full and m_ready is low.
module ascii_integer_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [aip_pkg::CHAR_W-1:0]     s_char_code,
    input  logic                           s_is_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [aip_pkg::MAG_W-1:0]      m_value,
    output logic [1:0]                     m_status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aip_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aip_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aip_pkg::*;

    logic [1:0]        sign_mode_reg;
    logic [2:0]        base_mode_reg;
    logic              result_signed_reg;
    logic [1:0]        result_width_reg;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    state_t            st_reg;
    state_t            st_next;
    state_t            st_step;

    logic              fin_valid_reg;
    fin_t              fin_reg;
    fin_t              fin_next;

    logic              out_valid_reg;
    logic [MAG_W-1:0]  out_value_reg;
    status_t           out_status_reg;
    logic [MAG_W-1:0]  out_value_next;
    status_t           out_status_next;

    logic              out_ld;
    logic              fin_free;
    logic              proc;

    assign out_ld   = fin_valid_reg && (!out_valid_reg || m_ready);
    assign fin_free = !fin_valid_reg || out_ld;
    assign proc     = in_valid_reg && (!in_last_reg || fin_free);
    assign s_ready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    aip_step u_step (
        .ch        (in_char_reg),
        .sign_mode (sign_mode_reg),
        .base_mode (base_mode_reg),
        .st_cur    (st_reg),
        .st_upd    (st_step)
    );

    // a last character sends the position back to zero
    always_comb begin
        st_next = st_step;
        if (in_last_reg) st_next.pos = 2'd0;
    end

    always_comb begin
        fin_next.mag   = st_step.mag;
        fin_next.neg   = st_step.neg;
        fin_next.err   = st_step.err;
        fin_next.sgn   = result_signed_reg;
        fin_next.width = result_width_reg;
    end

    aip_range u_range (
        .fin    (fin_reg),
        .value  (out_value_next),
        .status (out_status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_mode_reg     <= SIGN_DETECT;
            base_mode_reg     <= BASE_MODE_AUTO;
            result_signed_reg <= 1'b0;
            result_width_reg  <= WIDTH_64;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_SIGN_MODE:     sign_mode_reg     <= cfg_data[1:0];
                REG_BASE_MODE:     base_mode_reg     <= cfg_data;
                REG_RESULT_SIGNED: result_signed_reg <= cfg_data[0];
                REG_RESULT_WIDTH:  result_width_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_is_last;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // string state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.pos <= 2'd0;
        end else if (proc) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_last_reg) fin_reg <= fin_next;
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (proc && in_last_reg) begin
            fin_valid_reg <= 1'b1;
        end else if (out_ld) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ld) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

endmodule

@@ rtl/aip_checker.sv @@
module aip_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [aip_pkg::MAG_W-1:0]      m_value,
    input logic [1:0]                     m_status
);
    import aip_pkg::*;

    // coming out of reset the block is empty on both sides
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // a failed string always reads as zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_value == '0)
        else $error("nonzero value with error status");

    // handshakes stay known, and a shown result carries known bits
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_valid, s_ready, m_valid})
        && (!m_valid || !$isunknown({m_value, m_status})))
        else $error("unknown bits on the ports");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result changed while stalled");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_value  (m_value),
    .m_status (m_status)
);

@@ tb/ascii_integer_parser_checker.sv @@
`timescale 1ns / 1ps

module ascii_integer_parser_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [aip_pkg::CHAR_W-1:0]     s_char_code,
    input  logic                           s_is_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [aip_pkg::MAG_W-1:0]      m_value,
    input  logic [1:0]                     m_status,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [aip_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aip_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import aip_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] value;
        status_t          status;
    } parse_result_t;

    // register copies
    logic [1:0]       sign_mode_r;
    logic [2:0]       base_mode_r;
    logic             signed_r;
    logic [1:0]       width_r;

    // per-string state
    logic [1:0]       char_pos;
    logic [MAG_W-1:0] accum;
    logic             minus;
    base_t            radix_sel;
    logic             had_sign;
    logic             had_zero;
    logic             zero_held;
    logic             had_digit;
    status_t          latched;

    parse_result_t    expected_numbers [$];
    parse_result_t    want;
    int               fails = 0;

    function automatic int char_digit(logic [CHAR_W-1:0] ch, base_t b);
        int d;
        d = -1;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = int'(ch - CH_ZERO);
        end else if (b == BASE_HEX && ch >= CH_LO_A && ch <= CH_LO_F) begin
            d = int'(ch - CH_LO_A) + 10;
        end else if (b == BASE_HEX && ch >= CH_UP_A && ch <= CH_UP_F) begin
            d = int'(ch - CH_UP_A) + 10;
        end
        if (b == BASE_BIN && d > 1) d = -1;
        if (b == BASE_OCT && d > 7) d = -1;
        return d;
    endfunction

    function automatic logic auto_base();
        return base_mode_r >= BASE_MODE_AUTO;
    endfunction

    task automatic load_string();
        char_pos  = '0;
        accum     = '0;
        minus     = (sign_mode_r == SIGN_NEG);
        radix_sel = auto_base() ? BASE_DEC : base_t'(base_mode_r[1:0]);
        had_sign  = 1'b0;
        had_zero  = 1'b0;
        zero_held = 1'b0;
        had_digit = 1'b0;
        latched   = ST_OK;
    endtask

    task automatic push_digit(input logic [CHAR_W-1:0] ch, output status_t st);
        int          d;
        logic [71:0] r;
        logic [71:0] wide;
        d = char_digit(ch, radix_sel);
        case (radix_sel)
            BASE_BIN: r = 72'd2;
            BASE_OCT: r = 72'd8;
            BASE_DEC: r = 72'd10;
            default:  r = 72'd16;
        endcase
        if (d < 0) begin
            st = ST_BAD_DIGIT;
        end else begin
            wide = {8'd0, accum} * r + 72'(d);
            if (wide[71:64] != 8'd0) begin
                st = ST_RANGE;
            end else begin
                accum = wide[63:0];
                st    = ST_OK;
            end
        end
    endtask

    task automatic scan_prefix(input logic [CHAR_W-1:0] ch, output status_t st);
        st = ST_OK;
        if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (sign_mode_r == SIGN_POS || sign_mode_r == SIGN_NEG) begin
                st = ST_BAD_SIGN;
            end else if (had_sign || had_zero || had_digit) begin
                st = ST_BAD_DIGIT;
            end else begin
                minus    = (ch == CH_MINUS);
                had_sign = 1'b1;
            end
        end else if (ch == CH_ZERO) begin
            if (!auto_base() || had_digit) begin
                push_digit(ch, st);
            end else begin
                had_zero  = 1'b1;
                zero_held = 1'b1;
            end
        end else if (ch == CH_LO_B || ch == CH_LO_O || ch == CH_LO_X) begin
            if (!auto_base() || !zero_held) begin
                push_digit(ch, st);
            end else begin
                radix_sel = (ch == CH_LO_B) ? BASE_BIN : (ch == CH_LO_O) ? BASE_OCT : BASE_HEX;
                zero_held = 1'b0;
            end
        end else begin
            // a held zero goes in ahead of any other character
            if (zero_held) begin
                zero_held = 1'b0;
                push_digit(CH_ZERO, st);
            end
            if (st == ST_OK) begin
                had_digit = 1'b1;
                push_digit(ch, st);
            end
        end
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic last);
        status_t          st;
        logic [MAG_W-1:0] val;
        logic [MAG_W-1:0] lim;
        int               bits;
        if (char_pos == 2'd0) load_string();
        if (latched == ST_OK) begin
            if (char_pos < POS_MAX) scan_prefix(ch, st);
            else push_digit(ch, st);
            if (st != ST_OK) latched = st;
        end
        if (char_pos < POS_MAX) char_pos = char_pos + 2'd1;
        if (last) begin
            st   = latched;
            val  = '0;
            bits = 8 << width_r;
            if (st == ST_OK && accum != '0) begin
                if (!signed_r) begin
                    lim = (bits == 64) ? {MAG_W{1'b1}} : (64'd1 << bits) - 64'd1;
                    if (accum > lim || minus) st = ST_RANGE;
                    else val = accum;
                end else if (!minus) begin
                    lim = (64'd1 << (bits - 1)) - 64'd1;
                    if (accum > lim) st = ST_RANGE;
                    else val = accum;
                end else begin
                    lim = 64'd1 << (bits - 1);
                    if (accum > lim) st = ST_RANGE;
                    else val = 64'd0 - accum;
                end
            end
            if (st != ST_OK) val = '0;
            expected_numbers.push_back('{val, st});
            load_string();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sign_mode_r = SIGN_DETECT;
            base_mode_r = BASE_MODE_AUTO;
            signed_r    = 1'b0;
            width_r     = WIDTH_64;
            load_string();
            expected_numbers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    $display("%0t: result with nothing expected: value %h status %0d",
                             $time, m_value, m_status);
                    fails++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_value !== want.value) begin
                        $display("%0t: value mismatch: expected %h actual %h",
                                 $time, want.value, m_value);
                        fails++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_status);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SIGN_MODE:     sign_mode_r = cfg_data[1:0];
                    REG_BASE_MODE:     base_mode_r = cfg_data;
                    REG_RESULT_SIGNED: signed_r    = cfg_data[0];
                    REG_RESULT_WIDTH:  width_r     = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) parse_char(s_char_code, s_is_last);
        end
        mismatches  <= fails;
        outstanding <= expected_numbers.size();
    end

endmodule

@@ tb/ascii_integer_parser_tb.sv @@
`timescale 1ns / 1ps

module ascii_integer_parser_tb;
    import aip_pkg::*;

    // register values outside the documented range
    localparam logic [1:0] SIGN_DETECT_ALT = 2'd3;
    localparam logic [2:0] BASE_MODE_TOP   = 3'd7;
    localparam int         PHASES          = 12;
    localparam int         PHASE_CHARS     = 125;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_char_code;
    logic                  s_is_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [MAG_W-1:0]      m_value;
    logic [1:0]            m_status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    outstanding;

    logic [CHAR_W-1:0]     text [$];
    logic [1:0]            cur_sm;
    logic [2:0]            cur_bm;
    logic                  steady;
    int                    chars_sent;

    ascii_integer_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    ascii_integer_parser_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(int d);
        if (d < 10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= ch;
        s_is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic load_text(input string s);
        int i;
        text.delete();
        for (i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    // hold the sender until every result is back, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] sm, input logic [2:0] bm,
                              input logic sg, input logic [1:0] w);
        write_reg(REG_SIGN_MODE, {1'($urandom), sm});
        write_reg(REG_BASE_MODE, bm);
        write_reg(REG_RESULT_SIGNED, {2'($urandom), sg});
        write_reg(REG_RESULT_WIDTH, {1'($urandom), w});
        cfg_valid <= 1'b0;
        cur_sm = sm;
        cur_bm = bm;
    endtask

    task automatic build_text();
        logic [MAG_W-1:0]  v;
        logic [MAG_W-1:0]  rr;
        logic [CHAR_W-1:0] digs [0:71];
        int                n;
        int                k;
        int                i;
        base_t             b;
        logic              is_auto;
        text.delete();
        if ($urandom_range(0, 99) < 20) begin
            // noise: random bytes mixed with the characters that matter
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 1)) begin
                    text.push_back(8'($urandom_range(0, 255)));
                end else begin
                    case ($urandom_range(0, 9))
                        0: text.push_back(CH_PLUS);
                        1: text.push_back(CH_MINUS);
                        2: text.push_back(CH_ZERO);
                        3: text.push_back(CH_LO_B);
                        4: text.push_back(CH_LO_O);
                        5: text.push_back(CH_LO_X);
                        6: text.push_back(CH_NINE);
                        7: text.push_back(CH_UP_F);
                        8: text.push_back("g");
                        default: text.push_back(CH_LO_A);
                    endcase
                end
            end
        end else begin
            is_auto = (cur_bm >= BASE_MODE_AUTO);
            if (cur_sm == SIGN_POS || cur_sm == SIGN_NEG) begin
                if ($urandom_range(0, 99) < 8)
                    text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            end else if ($urandom_range(0, 1)) begin
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            end
            b = is_auto ? BASE_DEC : base_t'(cur_bm[1:0]);
            if ($urandom_range(0, 99) < (is_auto ? 60 : 10)) begin
                k = $urandom_range(0, 2);
                text.push_back(CH_ZERO);
                text.push_back(k == 0 ? CH_LO_B : k == 1 ? CH_LO_O : CH_LO_X);
                if (is_auto) b = (k == 0) ? BASE_BIN : (k == 1) ? BASE_OCT : BASE_HEX;
            end
            if ($urandom_range(0, 99) < 15) text.push_back(CH_ZERO);
            // magnitudes clustered around the target limits
            case ($urandom_range(0, 4))
                0: k = 8;
                1: k = 16;
                2: k = 32;
                3: k = 64;
                default: k = $urandom_range(1, 64);
            endcase
            k = k + $urandom_range(0, 2) - 1;
            if (k < 1) k = 1;
            if (k > 64) k = 64;
            case ($urandom_range(0, 7))
                0: v = '0;
                1: v = {$urandom, $urandom} >> (64 - k);
                2: v = 64'd1 << (k - 1);
                3: v = (64'd1 << (k - 1)) + 64'd1;
                4: v = (64'd1 << (k - 1)) - 64'd1;
                5: v = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - k);
                6: v = (64'hFFFF_FFFF_FFFF_FFFF >> (64 - k)) + 64'd1;
                default: v = 64'($urandom_range(0, 300));
            endcase
            case (b)
                BASE_BIN: rr = 64'd2;
                BASE_OCT: rr = 64'd8;
                BASE_DEC: rr = 64'd10;
                default:  rr = 64'd16;
            endcase
            n = 0;
            do begin
                digs[n] = digit_char(int'(v % rr));
                v = v / rr;
                n++;
            end while (v != '0);
            for (i = n - 1; i >= 0; i--) text.push_back(digs[i]);
            // one more digit pushes large values past 64 bits
            if ($urandom_range(0, 99) < 10)
                text.push_back(digit_char($urandom_range(0, int'(rr) - 1)));
            if ($urandom_range(0, 99) < 6)
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            n = idle_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8) : $urandom_range(20, 200);
            repeat (n) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #2000000;
        $display("ascii_integer_parser_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int         phase;
        int         start;
        logic [1:0] sm;
        logic [2:0] bm;
        logic       sg;
        logic [1:0] w;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = '0;
        s_is_last   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        steady      = 1'b0;
        chars_sent  = 0;
        cur_sm      = SIGN_DETECT;
        cur_bm      = BASE_MODE_AUTO;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: detected sign and base, unsigned 64-bit target
        load_text("7");    send_text();
        load_text("-5");   send_text();   // negative into unsigned
        load_text("0x1F"); send_text();
        load_text("0b10"); send_text();
        load_text("0o7");  send_text();
        load_text("+-1");  send_text();   // second sign
        load_text("12-");  send_text();   // sign after a digit
        text.delete();
        text.push_back(8'hFF);
        send_text();
        drain();
        set_config(SIGN_POS, {1'b0, BASE_DEC}, 1'b1, WIDTH_8);
        load_text("+3");   send_text();   // sign while forced
        load_text("128");  send_text();   // one past signed 8-bit max

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    sm = SIGN_DETECT;     bm = BASE_MODE_AUTO;   sg = 1'b1; w = WIDTH_8;
                end
                1: begin
                    sm = SIGN_NEG;        bm = {1'b0, BASE_HEX}; sg = 1'b1; w = WIDTH_64;
                end
                2: begin
                    sm = SIGN_DETECT_ALT; bm = BASE_MODE_TOP;    sg = 1'b0; w = WIDTH_8;
                end
                3: begin
                    sm = SIGN_DETECT;     bm = {1'b0, BASE_BIN}; sg = 1'b0; w = WIDTH_64;
                end
                default: begin
                    sm = $urandom_range(0, 1) ? SIGN_DETECT : 2'($urandom_range(0, 3));
                    bm = $urandom_range(0, 1) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
                    sg = 1'($urandom);
                    w  = 2'($urandom_range(0, 3));
                end
            endcase
            drain();
            set_config(sm, bm, sg, w);
            steady = (phase % 4 == 2);
            start  = chars_sent;
            while (chars_sent - start < PHASE_CHARS) begin
                build_text();
                send_text();
                if ($urandom_range(0, 99) < 3) drain();
            end
        end
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("ascii_integer_parser_tb: PASS");
        end else begin
            $display("ascii_integer_parser_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/aip_pkg.sv
rtl/aip_step.sv
rtl/aip_range.sv
rtl/ascii_integer_parser.sv
rtl/aip_checker.sv
tb/ascii_integer_parser_checker.sv
tb/ascii_integer_parser_tb.sv
